FILE: rtl/scc_pkg.sv
package scc_pkg;

   // field widths of the request and response items
   localparam int NODE_W  = 6;
   localparam int COMP_W  = 6;
   localparam int LEVEL_W = 3;
   localparam int COUNT_W = 7;

   // levels at or above this are never part of the graph
   localparam int LEVELS = 8;

   // request operation codes
   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   // one response waiting for its flags to settle
   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] node;
      logic [COMP_W-1:0] comp;
      logic              last_comp;
   } result_type;

endpackage

FILE: rtl/strongly_connected_components.sv
// Strongly connected components finder. After reset the block clears both adjacency memories
// a row at a time and takes no request meanwhile. An edge request (op 0) does a row read,
// then the merged row is written back into the forward and the reverse
// adjacency memories. A run request (op 1) first walks the forward graph depth first from
// node 0 upward, then walks the reverse graph from the latest finished nodes, and returns one
// response per node with its component number, flagging the last node of each component and
// of the run. The walk uses one neighbour test per cycle; in each of the two walks every node
// scans its row once, with a fetch, a finish step, a pop with a refetch and a root step. Any
// stall on the response side holds the run, and afterwards both memories are cleared. The
// block takes no request until the run has finished.
module strongly_connected_components #(
   parameter int MAX_NODES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [scc_pkg::LEVEL_W-1:0] csr_write_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_op,
   input  logic [scc_pkg::NODE_W-1:0]  req_src_node,
   input  logic [scc_pkg::NODE_W-1:0]  req_dst_node,
   input  logic [scc_pkg::LEVEL_W-1:0] req_edge_level,
   input  logic [scc_pkg::COUNT_W-1:0] req_node_count,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [scc_pkg::NODE_W-1:0]  rsp_node_index,
   output logic [scc_pkg::COMP_W-1:0]  rsp_component_index,
   output logic                        rsp_last_in_component,
   output logic                        rsp_last_overall
);

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int STK_W = IDX_W + CNT_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EWRITE = 4'd1;
   localparam logic [3:0] S_ROOT   = 4'd2;
   localparam logic [3:0] S_FETCH  = 4'd3;
   localparam logic [3:0] S_SCAN   = 4'd4;
   localparam logic [3:0] S_POP    = 4'd5;
   localparam logic [3:0] S_RROOT  = 4'd6;
   localparam logic [3:0] S_RWAIT  = 4'd7;
   localparam logic [3:0] S_FLUSH  = 4'd8;
   localparam logic [3:0] S_CLEAR  = 4'd9;

   // memories
   logic [MAX_NODES-1:0] fwd_mem [MAX_NODES];
   logic [MAX_NODES-1:0] rev_mem [MAX_NODES];
   logic [IDX_W-1:0]     fin_mem [MAX_NODES];
   logic [STK_W-1:0]     stk_mem [MAX_NODES];

   logic [MAX_NODES-1:0] fwd_rd_ff, rev_rd_ff;
   logic [IDX_W-1:0]     fin_rd_ff;
   logic [STK_W-1:0]     stk_rd_ff;

   logic [3:0]                  state_ff, state_in;
   logic [scc_pkg::LEVEL_W-1:0] min_level_ff;
   logic [scc_pkg::NODE_W-1:0]  src_ff, src_in, dst_ff, dst_in;
   logic                        edge_ok_ff, edge_ok_in;
   logic                        phase_ff, phase_in;
   logic [CNT_W-1:0]            n_ff, n_in;
   logic [CNT_W-1:0]            v_ff, v_in;
   logic [CNT_W-1:0]            fin_cnt_ff, fin_cnt_in;
   logic [CNT_W-1:0]            sp_ff, sp_in;
   logic [CNT_W-1:0]            comp_ff, comp_in;
   logic [IDX_W-1:0]            top_node_ff, top_node_in;
   logic [CNT_W-1:0]            top_j_ff, top_j_in;
   logic [MAX_NODES-1:0]        visited_ff, visited_in;
   logic [IDX_W-1:0]            clr_ff, clr_in;
   scc_pkg::result_type         pend_ff, pend_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [scc_pkg::NODE_W-1:0]  rsp_node_ff, rsp_node_in;
   logic [scc_pkg::COMP_W-1:0]  rsp_comp_ff, rsp_comp_in;
   logic                        rsp_lastc_ff, rsp_lastc_in;
   logic                        rsp_lasto_ff, rsp_lasto_in;

   logic                 fwd_we, rev_we, fin_we, stk_we;
   logic [IDX_W-1:0]     fwd_wa, rev_wa, fwd_ra, rev_ra;
   logic [MAX_NODES-1:0] fwd_wd, rev_wd;
   logic [STK_W-1:0]     stk_wd;
   logic [IDX_W-1:0]     stk_ra;
   logic [IDX_W-1:0]     fin_ra;
   logic [MAX_NODES-1:0] dst_mask, src_mask, adj_row;
   logic                 out_free, edge_ok, req_take;
   logic [CNT_W-1:0]     cnt_sat;
   logic [IDX_W-1:0]     j_idx;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign adj_row   = phase_ff ? rev_rd_ff : fwd_rd_ff;
   assign j_idx     = top_j_ff[IDX_W-1:0];
   assign stk_ra    = IDX_W'(sp_ff - CNT_W'(1));
   assign fin_ra    = IDX_W'(v_ff - CNT_W'(1));

   // qualify an incoming edge
   assign edge_ok = ({1'b0, req_src_node} < 7'(MAX_NODES))
                    && ({1'b0, req_dst_node} < 7'(MAX_NODES))
                    && (req_src_node != req_dst_node)
                    && (req_edge_level >= min_level_ff)
                    && ({1'b0, req_edge_level} < 4'(scc_pkg::LEVELS));

   // saturate the node count
   assign cnt_sat = (req_node_count > 7'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                    : CNT_W'(req_node_count);

   // one-hot bits of the stored edge ends
   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         dst_mask[i] = (dst_ff == scc_pkg::NODE_W'(i));
         src_mask[i] = (src_ff == scc_pkg::NODE_W'(i));
      end
   end

   // memory ports
   always_comb begin
      fwd_ra = (state_ff == S_IDLE) ? IDX_W'(req_src_node) : top_node_ff;
      rev_ra = (state_ff == S_IDLE) ? IDX_W'(req_dst_node) : top_node_ff;
      fwd_we = ((state_ff == S_EWRITE) && edge_ok_ff) || (state_ff == S_CLEAR);
      rev_we = fwd_we;
      fwd_wa = (state_ff == S_CLEAR) ? clr_ff : IDX_W'(src_ff);
      rev_wa = (state_ff == S_CLEAR) ? clr_ff : IDX_W'(dst_ff);
      fwd_wd = (state_ff == S_CLEAR) ? '0 : (fwd_rd_ff | dst_mask);
      rev_wd = (state_ff == S_CLEAR) ? '0 : (rev_rd_ff | src_mask);
   end

   always_ff @(posedge clock) begin
      if (fwd_we) begin
         fwd_mem[fwd_wa] <= fwd_wd;
      end
      fwd_rd_ff <= fwd_mem[fwd_ra];
   end

   always_ff @(posedge clock) begin
      if (rev_we) begin
         rev_mem[rev_wa] <= rev_wd;
      end
      rev_rd_ff <= rev_mem[rev_ra];
   end

   always_ff @(posedge clock) begin
      if (fin_we) begin
         fin_mem[fin_cnt_ff[IDX_W-1:0]] <= top_node_ff;
      end
      fin_rd_ff <= fin_mem[fin_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[sp_ff[IDX_W-1:0]] <= stk_wd;
      end
      stk_rd_ff <= stk_mem[stk_ra];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      edge_ok_in   = edge_ok_ff;
      phase_in     = phase_ff;
      n_in         = n_ff;
      v_in         = v_ff;
      fin_cnt_in   = fin_cnt_ff;
      sp_in        = sp_ff;
      comp_in      = comp_ff;
      top_node_in  = top_node_ff;
      top_j_in     = top_j_ff;
      visited_in   = visited_ff;
      clr_in       = clr_ff;
      pend_in      = pend_ff;
      fin_we       = 1'b0;
      stk_we       = 1'b0;
      stk_wd       = {CNT_W'(top_j_ff + CNT_W'(1)), top_node_ff};
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_node_in  = rsp_node_ff;
      rsp_comp_in  = rsp_comp_ff;
      rsp_lastc_in = rsp_lastc_ff;
      rsp_lasto_in = rsp_lasto_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_op == scc_pkg::OP_EDGE) begin
                  src_in     = req_src_node;
                  dst_in     = req_dst_node;
                  edge_ok_in = edge_ok;
                  state_in   = S_EWRITE;
               end else begin
                  n_in       = cnt_sat;
                  v_in       = '0;
                  fin_cnt_in = '0;
                  visited_in = '0;
                  phase_in   = 1'b0;
                  pend_in    = '0;
                  state_in   = S_ROOT;
               end
            end
         end

         S_EWRITE: begin
            state_in = S_IDLE;
         end

         // pick the next forward root
         S_ROOT: begin
            if (v_ff >= n_ff) begin
               phase_in   = 1'b1;
               visited_in = '0;
               v_in       = fin_cnt_ff;
               comp_in    = '0;
               state_in   = S_RROOT;
            end else if (visited_ff[v_ff[IDX_W-1:0]]) begin
               v_in = v_ff + CNT_W'(1);
            end else begin
               visited_in[v_ff[IDX_W-1:0]] = 1'b1;
               top_node_in = v_ff[IDX_W-1:0];
               top_j_in    = '0;
               sp_in       = '0;
               state_in    = S_FETCH;
            end
         end

         S_FETCH: begin
            state_in = S_SCAN;
         end

         // test one neighbour, or finish the node on top
         S_SCAN: begin
            if (top_j_ff < n_ff) begin
               if (adj_row[j_idx] && !visited_ff[j_idx]) begin
                  stk_we          = 1'b1;
                  sp_in           = sp_ff + CNT_W'(1);
                  visited_in[j_idx] = 1'b1;
                  top_node_in     = j_idx;
                  top_j_in        = '0;
                  state_in        = S_FETCH;
               end else begin
                  top_j_in = top_j_ff + CNT_W'(1);
               end
            end else if (!phase_ff || !pend_ff.valid || out_free) begin
               if (!phase_ff) begin
                  fin_we     = 1'b1;
                  fin_cnt_in = fin_cnt_ff + CNT_W'(1);
               end else begin
                  if (pend_ff.valid) begin
                     rsp_valid_in = 1'b1;
                     rsp_node_in  = pend_ff.node;
                     rsp_comp_in  = pend_ff.comp;
                     rsp_lastc_in = pend_ff.last_comp;
                     rsp_lasto_in = 1'b0;
                  end
                  pend_in.valid     = 1'b1;
                  pend_in.node      = scc_pkg::NODE_W'(top_node_ff);
                  pend_in.comp      = scc_pkg::COMP_W'(comp_ff);
                  pend_in.last_comp = (sp_ff == '0);
               end
               if (sp_ff == '0) begin
                  if (!phase_ff) begin
                     v_in     = v_ff + CNT_W'(1);
                     state_in = S_ROOT;
                  end else begin
                     comp_in  = comp_ff + CNT_W'(1);
                     state_in = S_RROOT;
                  end
               end else begin
                  state_in = S_POP;
               end
            end
         end

         // resume the parent node
         S_POP: begin
            top_node_in = stk_rd_ff[IDX_W-1:0];
            top_j_in    = stk_rd_ff[STK_W-1:IDX_W];
            sp_in       = sp_ff - CNT_W'(1);
            state_in    = S_FETCH;
         end

         S_RROOT: begin
            if (v_ff == '0) begin
               state_in = S_FLUSH;
            end else begin
               state_in = S_RWAIT;
            end
         end

         // take the latest finished node as reverse root
         S_RWAIT: begin
            v_in = v_ff - CNT_W'(1);
            if (visited_ff[fin_rd_ff]) begin
               state_in = S_RROOT;
            end else begin
               visited_in[fin_rd_ff] = 1'b1;
               top_node_in = fin_rd_ff;
               top_j_in    = '0;
               sp_in       = '0;
               state_in    = S_FETCH;
            end
         end

         // release the held response as the last of the run
         S_FLUSH: begin
            if (!pend_ff.valid) begin
               clr_in   = '0;
               state_in = S_CLEAR;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_node_in   = pend_ff.node;
               rsp_comp_in   = pend_ff.comp;
               rsp_lastc_in  = pend_ff.last_comp;
               rsp_lasto_in  = 1'b1;
               pend_in.valid = 1'b0;
               clr_in        = '0;
               state_in      = S_CLEAR;
            end
         end

         // wipe both adjacency memories a row at a time
         S_CLEAR: begin
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(MAX_NODES - 1)) begin
               visited_in = '0;
               fin_cnt_in = '0;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers; start with a clearing pass over the memories
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         min_level_ff <= '0;
         fin_cnt_ff   <= '0;
         visited_ff   <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         sp_ff        <= '0;
         v_ff         <= '0;
         n_ff         <= '0;
         comp_ff      <= '0;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_enable) begin
            min_level_ff <= csr_write_data;
         end
         fin_cnt_ff   <= fin_cnt_in;
         visited_ff   <= visited_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         sp_ff        <= sp_in;
         v_ff         <= v_in;
         n_ff         <= n_in;
         comp_ff      <= comp_in;
         clr_ff       <= clr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      edge_ok_ff   <= edge_ok_in;
      top_node_ff  <= top_node_in;
      top_j_ff     <= top_j_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_comp_ff  <= rsp_comp_in;
      rsp_lastc_ff <= rsp_lastc_in;
      rsp_lasto_ff <= rsp_lasto_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_node_index        = rsp_node_ff;
   assign rsp_component_index   = rsp_comp_ff;
   assign rsp_last_in_component = rsp_lastc_ff;
   assign rsp_last_overall      = rsp_lasto_ff;

endmodule

FILE: tb/strongly_connected_components_tb.sv
module strongly_connected_components_tb;

   localparam int NODES     = 64;
   localparam int WAIT_LIMIT = 40000;
   localparam int SETTLE    = 200;

   typedef struct {
      logic                         op;
      logic [scc_pkg::NODE_W-1:0]   src;
      logic [scc_pkg::NODE_W-1:0]   dst;
      logic [scc_pkg::LEVEL_W-1:0]  level;
      logic [scc_pkg::COUNT_W-1:0]  count;
   } request_type;

   typedef struct {
      logic [scc_pkg::NODE_W-1:0] node;
      logic [scc_pkg::COMP_W-1:0] comp;
      logic                       last_comp;
      logic                       last_all;
   } labelled_node_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [scc_pkg::LEVEL_W-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = 1'b0;
   logic [scc_pkg::NODE_W-1:0] req_src_node = '0;
   logic [scc_pkg::NODE_W-1:0] req_dst_node = '0;
   logic [scc_pkg::LEVEL_W-1:0] req_edge_level = '0;
   logic [scc_pkg::COUNT_W-1:0] req_node_count = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [scc_pkg::NODE_W-1:0] rsp_node_index;
   logic [scc_pkg::COMP_W-1:0] rsp_component_index;
   logic rsp_last_in_component;
   logic rsp_last_overall;

   request_type       pending_requests[$];
   labelled_node_type expected_labels[$];

   // graph copy used to predict component labels
   logic [NODES-1:0] fwd_rows[NODES];
   logic [NODES-1:0] rev_rows[NODES];
   logic [scc_pkg::LEVEL_W-1:0] level_floor = '0;

   int send_idle = 0;
   int recv_idle = 0;
   int errors = 0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   strongly_connected_components DUT (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_src_node(req_src_node), .req_dst_node(req_dst_node),
      .req_edge_level(req_edge_level), .req_node_count(req_node_count),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_node_index(rsp_node_index), .rsp_component_index(rsp_component_index),
      .rsp_last_in_component(rsp_last_in_component), .rsp_last_overall(rsp_last_overall)
   );

   // depth-first walk; either records finish order or labels one component
   task automatic dfs_walk(input bit use_rev, input int n, input int root,
                           inout logic [NODES-1:0] seen, inout int order[$],
                           input bit label, input int comp, inout int emitted);
      int node_stack[$];
      int next_try[$];
      int top, j, hit;
      logic [NODES-1:0] row;
      labelled_node_type lab;
      seen[root] = 1'b1;
      node_stack.insert(node_stack.size(), root);
      next_try.insert(next_try.size(), 0);
      while (node_stack.size() > 0) begin
         top = node_stack[$];
         row = use_rev ? rev_rows[top] : fwd_rows[top];
         hit = n;
         for (j = next_try[$]; j < n; j++) begin
            if (row[j] && !seen[j]) begin
               hit = j;
               break;
            end
         end
         if (hit < n && node_stack.size() < NODES) begin
            next_try[$] = hit + 1;
            seen[hit] = 1'b1;
            node_stack.insert(node_stack.size(), hit);
            next_try.insert(next_try.size(), 0);
         end else begin
            void'(node_stack.pop_back());
            void'(next_try.pop_back());
            if (!label) begin
               if (order.size() < NODES) order.insert(order.size(), top);
            end else if (emitted < NODES) begin
               lab.node      = top[scc_pkg::NODE_W-1:0];
               lab.comp      = comp[scc_pkg::COMP_W-1:0];
               lab.last_comp = 1'b0;
               lab.last_all  = 1'b0;
               expected_labels.insert(expected_labels.size(), lab);
               emitted++;
            end
         end
      end
   endtask

   // apply one accepted request to the graph copy and queue its labels
   task automatic predict_request(input request_type r);
      logic [NODES-1:0] seen;
      int order[$];
      int n, v, comp, emitted, prior, root;
      if (r.op == scc_pkg::OP_EDGE) begin
         if (r.src != r.dst && r.level >= level_floor) begin
            fwd_rows[r.src][r.dst] = 1'b1;
            rev_rows[r.dst][r.src] = 1'b1;
         end
      end else begin
         n = (r.count > NODES) ? NODES : r.count;
         seen = '0;
         emitted = 0;
         comp = 0;
         for (v = 0; v < n; v++)
            if (!seen[v]) dfs_walk(1'b0, n, v, seen, order, 1'b0, 0, emitted);
         seen = '0;
         for (v = order.size(); v > 0; v--) begin
            root = order[v-1];
            if (seen[root]) continue;
            prior = emitted;
            dfs_walk(1'b1, n, root, seen, order, 1'b1, comp, emitted);
            if (emitted > prior) expected_labels[$].last_comp = 1'b1;
            comp++;
         end
         if (emitted > 0) expected_labels[$].last_all = 1'b1;
         for (v = 0; v < NODES; v++) begin
            fwd_rows[v] = '0;
            rev_rows[v] = '0;
         end
      end
   endtask

   // drive requests from the pending queue
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_request(pending_requests.pop_front());
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_valid      <= 1'b1;
               req_op         <= pending_requests[0].op;
               req_src_node   <= pending_requests[0].src;
               req_dst_node   <= pending_requests[0].dst;
               req_edge_level <= pending_requests[0].level;
               req_node_count <= pending_requests[0].count;
            end else begin
               req_valid <= 1'b0;
            end
         end
         // the front entry is already on the port once valid is up
      end
   end

   // check responses and toggle the receiver stall
   always @(posedge clock) begin
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
         if (rsp_valid && !rsp_stall) begin
            if (expected_labels.size() == 0) begin
               $display("%0t: unexpected response node %0d comp %0d", $time,
                        rsp_node_index, rsp_component_index);
               errors++;
            end else begin
               labelled_node_type e;
               e = expected_labels.pop_front();
               if (e.node !== rsp_node_index || e.comp !== rsp_component_index ||
                   e.last_comp !== rsp_last_in_component ||
                   e.last_all !== rsp_last_overall) begin
                  $display({"%0t: mismatch expected node %0d comp %0d last %0b end %0b,",
                            " got %0d %0d %0b %0b"},
                           $time, e.node, e.comp, e.last_comp, e.last_all, rsp_node_index,
                           rsp_component_index, rsp_last_in_component, rsp_last_overall);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no request or response moving
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WAIT_LIMIT) begin
         $display("strongly_connected_components_tb failed");
         $finish;
      end
   end

   function automatic request_type edge_req(input int s, input int d, input int lv);
      request_type r;
      r.op    = scc_pkg::OP_EDGE;
      r.src   = scc_pkg::NODE_W'(s);
      r.dst   = scc_pkg::NODE_W'(d);
      r.level = scc_pkg::LEVEL_W'(lv);
      r.count = scc_pkg::COUNT_W'($urandom);
      return r;
   endfunction

   function automatic request_type run_req(input int n);
      request_type r;
      r.op    = scc_pkg::OP_RUN;
      r.src   = scc_pkg::NODE_W'($urandom);
      r.dst   = scc_pkg::NODE_W'($urandom);
      r.level = scc_pkg::LEVEL_W'($urandom);
      r.count = scc_pkg::COUNT_W'(n);
      return r;
   endfunction

   // queue one request at the back of the pending list
   task automatic queue_request(input request_type r);
      pending_requests.insert(pending_requests.size(), r);
   endtask

   // queue a random graph and its run
   task automatic queue_graph(input int n, input int edges);
      int e, s;
      for (e = 0; e < edges; e++) begin
         s = $urandom_range(n - 1);
         if ($urandom_range(9) == 0)
            queue_request(edge_req($urandom_range(63), $urandom_range(63),
                                   $urandom_range(7)));
         else if ($urandom_range(4) == 0)
            queue_request(edge_req(s, ($urandom_range(1) ? s + 1 : 0) % n,
                                   $urandom_range(7)));
         else
            queue_request(edge_req(s, $urandom_range(n - 1), $urandom_range(7)));
      end
      queue_request(run_req(n));
   endtask

   // wait until the block is drained and idle
   task automatic drain;
      while (pending_requests.size() > 0 || req_valid || expected_labels.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_floor(input int lv);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= scc_pkg::LEVEL_W'(lv);
      level_floor = scc_pkg::LEVEL_W'(lv);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int i, phase;
      for (i = 0; i < NODES; i++) begin
         fwd_rows[i] = '0;
         rev_rows[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: cycle, self edge, duplicate, out-of-range, zero and saturated counts
      set_floor(0);
      queue_request(edge_req(0, 1, 0));
      queue_request(edge_req(1, 2, 7));
      queue_request(edge_req(2, 0, 3));
      queue_request(edge_req(2, 0, 3));
      queue_request(edge_req(3, 3, 5));
      queue_request(edge_req(3, 9, 1));
      queue_request(edge_req(63, 62, 2));
      queue_request(run_req(5));
      queue_request(edge_req(0, 1, 0));
      queue_request(run_req(0));
      queue_request(run_req(1));
      queue_request(edge_req(62, 63, 4));
      queue_request(edge_req(63, 0, 6));
      queue_request(edge_req(0, 62, 1));
      queue_request(run_req(127));
      drain();
      set_floor(7);
      queue_request(edge_req(0, 1, 6));
      queue_request(edge_req(1, 0, 7));
      queue_request(edge_req(0, 2, 7));
      queue_request(run_req(64));
      drain();

      // random graphs under three idling patterns
      for (phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 31 : (phase == 1) ? 45 : 0;
         recv_idle = (phase == 0) ? 45 : (phase == 1) ? 31 : 0;
         set_floor(phase == 2 ? 0 : $urandom_range(7));
         for (i = 0; i < 5; i++)
            queue_graph($urandom_range(1, 12), $urandom_range(4, 14));
         if (phase == 1) queue_graph(64, 8);
         drain();
      end
      set_floor(3);
      queue_graph(20, 12);
      drain();

      if (errors == 0)
         $display("strongly_connected_components_tb passed");
      else
         $display("strongly_connected_components_tb failed");
      $finish;
   end

endmodule
